@@ sv/slkm_pkg.sv @@
`default_nettype none

package slkm_pkg;

    localparam int LEVEL_W = 4;
    localparam int TIME_W  = 32;
    localparam int LONG_W  = 16;
    localparam int SCAN_W  = 10;
    localparam int CODE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 16;

    localparam logic [CFG_AW-1:0] CFG_ACTIVE_GROUP = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_LONG_PRESS   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_SCAN_INTVL   = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    localparam logic [1:0] PH_RELEASED = 2'd0;
    localparam logic [1:0] PH_PRESSED  = 2'd1;
    localparam logic [1:0] PH_LONG     = 2'd2;

    localparam logic [LONG_W-1:0] RST_LONG_MS = 16'd1000;
    localparam logic [SCAN_W-1:0] RST_SCAN_MS = 10'd50;

    localparam logic [WORD_W-1:0] DEFAULT_MAP [2][2][4] = '{
        '{'{16'h0004, 16'h0005, 16'h0106, 16'h0007},
          '{16'h0119, 16'h001A, 16'h001B, 16'h001C}},
        '{'{16'h0059, 16'h005A, 16'h005B, 16'h005C},
          '{16'h005F, 16'h0060, 16'h0061, 16'h0062}}
    };

    typedef struct packed {
        logic hit;
        logic is_long;
    } t_lane_evt;

    function automatic logic [WORD_W-1:0] f_default_word(
        input logic [2:0] grp,
        input logic       lng,
        input logic [3:0] btn
    );
        logic [WORD_W-1:0] word;
        word = '0;
        if (grp < 3'd2 && btn < 4'd4) begin
            word = DEFAULT_MAP[grp[0]][lng][btn[1:0]];
        end
        return word;
    endfunction

endpackage

`default_nettype wire

@@ sv/slkm_lane.sv @@
`default_nettype none

module slkm_lane (
    input  logic                            i_down,
    input  logic [1:0]                      i_phase,
    input  logic [slkm_pkg::TIME_W-1:0]     i_start,
    input  logic [slkm_pkg::TIME_W-1:0]     i_now_ms,
    input  logic [slkm_pkg::LONG_W-1:0]     i_long_ms,
    output logic [1:0]                      o_phase,
    output logic [slkm_pkg::TIME_W-1:0]     o_start,
    output slkm_pkg::t_lane_evt             o_evt
);

    logic [slkm_pkg::TIME_W-1:0] held;

    assign held = i_now_ms - i_start;

    always_comb begin
        o_phase       = i_phase;
        o_start       = i_start;
        o_evt.hit     = 1'b0;
        o_evt.is_long = 1'b0;
        unique case (i_phase)
            slkm_pkg::PH_RELEASED: begin
                if (i_down) begin
                    o_phase = slkm_pkg::PH_PRESSED;
                    o_start = i_now_ms;
                end
            end
            slkm_pkg::PH_PRESSED: begin
                if (!i_down) begin
                    o_phase   = slkm_pkg::PH_RELEASED;
                    o_evt.hit = 1'b1;
                end else if (held >= {{(slkm_pkg::TIME_W-slkm_pkg::LONG_W){1'b0}},
                                      i_long_ms}) begin
                    o_phase       = slkm_pkg::PH_LONG;
                    o_evt.hit     = 1'b1;
                    o_evt.is_long = 1'b1;
                end
            end
            slkm_pkg::PH_LONG: begin
                if (!i_down) begin
                    o_phase = slkm_pkg::PH_RELEASED;
                end
            end
            default: begin
                o_phase = slkm_pkg::PH_RELEASED;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/slkm_merge.sv @@
`default_nettype none

module slkm_merge #(
    parameter int BUTTONS = 4,
    parameter int BW      = 2
) (
    input  slkm_pkg::t_lane_evt i_evt [BUTTONS],
    output logic [BUTTONS-1:0]  o_upd,
    output logic                o_hit,
    output logic                o_long,
    output logic [BW-1:0]       o_idx
);

    always_comb begin
        o_hit  = 1'b0;
        o_long = 1'b0;
        o_idx  = '0;
        o_upd  = '0;
        for (int i = 0; i < BUTTONS; i++) begin
            o_upd[i] = !o_hit;
            if (!o_hit && i_evt[i].hit) begin
                o_hit  = 1'b1;
                o_long = i_evt[i].is_long;
                o_idx  = BW'(i);
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/short_long_keypress_mapper.sv @@
// Short and long keypress mapper.
// The input channel (i_in_valid/o_in_ready) carries one transaction per item.
// A sample transaction (operation 0) scans the buttons when at least the scan
// interval has passed since the last scan; a write transaction (operation 1)
// stores one key code in the key map. Every input transaction gives exactly
// one output transaction on o_out_valid/i_out_ready, with report_valid set
// when a nonzero key word was found.
// The result shows in the cycle after the accept: the scan runs on parallel
// per-button lanes and a priority merge in the accept cycle, and the key map
// read is registered into the output stage. Throughput is one transaction
// per cycle unless the receiver stalls; then the output holds and o_in_ready
// follows i_out_ready, so no more than one result is ever pending.
// The configuration port is to be written with i_cfg_we, i_cfg_addr and
// i_cfg_wdata only while the block is idle; the block does not enforce this.
// Synchronous reset restores the default key map, clears all button
// phases and the scan time, and empties the output stage.
`default_nettype none

module short_long_keypress_mapper #(
    parameter int BUTTONS = 4,
    parameter int GROUPS  = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [slkm_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [slkm_pkg::CFG_DW-1:0]     i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_operation,
    input  logic [slkm_pkg::TIME_W-1:0]     i_now_ms,
    input  logic [slkm_pkg::LEVEL_W-1:0]    i_buttons_low,
    input  logic                            i_map_group,
    input  logic                            i_map_long,
    input  logic [1:0]                      i_map_index,
    input  logic [slkm_pkg::CODE_W-1:0]     i_map_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_report_valid,
    output logic [slkm_pkg::CODE_W-1:0]     o_modifier,
    output logic [slkm_pkg::CODE_W-1:0]     o_key_code
);

    localparam int SLOTS = GROUPS * 2 * BUTTONS;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BW    = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

    logic                            r_active_group;
    logic [slkm_pkg::LONG_W-1:0]     r_long_ms;
    logic [slkm_pkg::SCAN_W-1:0]     r_scan_ms;
    logic [slkm_pkg::TIME_W-1:0]     r_last;
    logic [1:0]                      r_phase [BUTTONS];
    logic [slkm_pkg::TIME_W-1:0]     r_start [BUTTONS];
    logic [slkm_pkg::CODE_W-1:0]     r_mem   [SLOTS];
    logic [SLOTS-1:0]                r_mvld;

    logic                            r_pend;
    logic                            r_hit;
    logic                            r_rd_grp;
    logic                            r_rd_long;
    logic [BW-1:0]                   r_rd_idx;
    logic [slkm_pkg::CODE_W-1:0]     r_rd_data;
    logic                            r_rd_mvld;

    logic [1:0]                      n_phase [BUTTONS];
    logic [slkm_pkg::TIME_W-1:0]     n_start [BUTTONS];
    slkm_pkg::t_lane_evt             lane_evt [BUTTONS];
    logic [BUTTONS-1:0]              down;
    logic [BUTTONS-1:0]              upd;
    logic                            pick_hit;
    logic                            pick_long;
    logic [BW-1:0]                   pick_idx;

    logic                            in_acc;
    logic [slkm_pkg::TIME_W-1:0]     since_scan;
    logic                            do_scan;
    logic                            wr_ok;
    logic                            do_write;
    logic [SW-1:0]                   rd_slot;
    logic [SW-1:0]                   wr_slot;
    logic [slkm_pkg::WORD_W-1:0]     def_word;
    logic [slkm_pkg::WORD_W-1:0]     word;
    logic                            report;

    assign o_in_ready = !r_pend || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign since_scan = i_now_ms - r_last;
    assign do_scan    = in_acc && (i_operation == slkm_pkg::OP_SAMPLE) &&
                        (since_scan >= {{(slkm_pkg::TIME_W-slkm_pkg::SCAN_W){1'b0}},
                                        r_scan_ms});
    assign wr_ok      = (int'(i_map_group) < GROUPS) && (int'(i_map_index) < BUTTONS);
    assign do_write   = in_acc && (i_operation == slkm_pkg::OP_WRITE) && wr_ok;
    assign rd_slot    = SW'((int'(r_active_group) * 2 + int'(pick_long)) * BUTTONS
                            + int'(pick_idx));
    assign wr_slot    = SW'((int'(i_map_group) * 2 + int'(i_map_long)) * BUTTONS
                            + int'(i_map_index));

    for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
        if (g < slkm_pkg::LEVEL_W) begin : g_level
            assign down[g] = !i_buttons_low[g];
        end else begin : g_beyond
            assign down[g] = 1'b1;
        end

        slkm_lane u_lane (
            .i_down    (down[g]),
            .i_phase   (r_phase[g]),
            .i_start   (r_start[g]),
            .i_now_ms  (i_now_ms),
            .i_long_ms (r_long_ms),
            .o_phase   (n_phase[g]),
            .o_start   (n_start[g]),
            .o_evt     (lane_evt[g])
        );
    end

    slkm_merge #(
        .BUTTONS (BUTTONS),
        .BW      (BW)
    ) u_merge (
        .i_evt  (lane_evt),
        .o_upd  (upd),
        .o_hit  (pick_hit),
        .o_long (pick_long),
        .o_idx  (pick_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_group <= 1'b0;
            r_long_ms      <= slkm_pkg::RST_LONG_MS;
            r_scan_ms      <= slkm_pkg::RST_SCAN_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                slkm_pkg::CFG_ACTIVE_GROUP: begin
                    if (GROUPS > 1 || !i_cfg_wdata[0]) begin
                        r_active_group <= i_cfg_wdata[0];
                    end
                end
                slkm_pkg::CFG_LONG_PRESS: r_long_ms <= i_cfg_wdata[slkm_pkg::LONG_W-1:0];
                slkm_pkg::CFG_SCAN_INTVL: r_scan_ms <= i_cfg_wdata[slkm_pkg::SCAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            for (int i = 0; i < BUTTONS; i++) begin
                r_phase[i] <= slkm_pkg::PH_RELEASED;
                r_start[i] <= '0;
            end
        end else if (do_scan) begin
            r_last <= i_now_ms;
            for (int i = 0; i < BUTTONS; i++) begin
                if (upd[i]) begin
                    r_phase[i] <= n_phase[i];
                    r_start[i] <= n_start[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[wr_slot] <= i_map_value;
        end
        if (do_scan) begin
            r_rd_data <= r_mem[rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld    <= '0;
            r_rd_mvld <= 1'b0;
        end else begin
            if (do_write) begin
                r_mvld[wr_slot] <= 1'b1;
            end
            if (do_scan) begin
                r_rd_mvld <= r_mvld[rd_slot];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_pend <= 1'b1;
                r_hit  <= do_scan && pick_hit;
            end else if (i_out_ready) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_scan) begin
            r_rd_grp  <= r_active_group;
            r_rd_long <= pick_long;
            r_rd_idx  <= pick_idx;
        end
    end

    assign def_word = slkm_pkg::f_default_word(3'(r_rd_grp), r_rd_long, 4'(r_rd_idx));
    assign word     = r_rd_mvld ? {{(slkm_pkg::WORD_W-slkm_pkg::CODE_W){1'b0}}, r_rd_data}
                                : def_word;
    assign report   = r_hit && (word != '0);

    assign o_out_valid    = r_pend;
    assign o_report_valid = report;
    assign o_modifier     = report ? word[slkm_pkg::WORD_W-1:slkm_pkg::CODE_W] : '0;
    assign o_key_code     = report ? word[slkm_pkg::CODE_W-1:0] : '0;

endmodule

`default_nettype wire

@@ sv/slkm_checker.sv @@
`default_nettype none

module slkm_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  logic                            i_operation,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic                            o_report_valid,
    input  logic [slkm_pkg::CODE_W-1:0]     o_modifier,
    input  logic [slkm_pkg::CODE_W-1:0]     o_key_code
);

    // A transaction without a report carries an all-zero key word.
    a_quiet_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_report_valid) |-> (o_modifier == '0 && o_key_code == '0))
        else $error("non-report transaction carries a key word");

    // A report never carries an all-zero key word.
    a_report_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_report_valid) |-> (o_modifier != '0 || o_key_code != '0))
        else $error("report transaction carries a zero key word");

    // A key map write is answered in the next cycle by a non-report transaction.
    a_write_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_operation == slkm_pkg::OP_WRITE)
        |=> (o_out_valid && !o_report_valid))
        else $error("key map write not answered as expected");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready)
        |=> (o_out_valid && $stable(o_report_valid) && $stable(o_modifier)
             && $stable(o_key_code)))
        else $error("stalled result changed");

endmodule

bind short_long_keypress_mapper slkm_checker u_slkm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_operation    (i_operation),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_report_valid (o_report_valid),
    .o_modifier     (o_modifier),
    .o_key_code     (o_key_code)
);

`default_nettype wire
